### hw/rtl/huffman_decoder_from_counts_defines.svh
// ----------------------------------------------------------------------------
// Huffman decoder assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_DECODER_FROM_COUNTS_DEFINES_SVH
`define HUFFMAN_DECODER_FROM_COUNTS_DEFINES_SVH

// property must hold at every edge outside reset
`define HDFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define HDFC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hw/rtl/hdfc_pkg.sv
// ----------------------------------------------------------------------------
// hdfc_pkg
// Types and constants shared by the Huffman decoder controller and datapath.
// ----------------------------------------------------------------------------
package hdfc_pkg;

  localparam int unsigned SymW    = 8;
  localparam int unsigned NodeW   = 9;
  localparam int unsigned CountW  = 24;
  localparam int unsigned WeightW = 32;
  localparam int unsigned Nodes   = 511;
  localparam int unsigned Inner   = 255;
  localparam int unsigned Symbols = 256;
  localparam int unsigned ChildW  = 2 * NodeW;
  localparam int unsigned InW     = 40;

  localparam logic [NodeW-1:0] RootNode   = 9'd510;
  localparam logic [NodeW-1:0] FirstInner = 9'd256;
  localparam logic [SymW-1:0]  EndSym     = 8'd18;

  localparam logic KindLoad = 1'b0;
  localparam logic KindByte = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StClr,
    StScanStart,
    StScan,
    StScanTail,
    StMark,
    StBitRd,
    StBitEv,
    StFlush
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic byte_start;
    logic clr_start;
    logic clr_step;
    logic scan_start;
    logic scan_step;
    logic mark;
    logic bit_eval;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic stream_done;
    logic tree_ready;
    logic clr_last;
    logic scan_last;
    logic second_pick;
    logic build_last;
    logic bit_last;
    logic leaf;
    logic end_hit;
    logic pend_valid;
    logic slot;
  } dp_stat_t;

endpackage

### hw/rtl/hdfc_ram.sv
// ----------------------------------------------------------------------------
// hdfc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hdfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/hdfc_ctrl.sv
// ----------------------------------------------------------------------------
// hdfc_ctrl
// Sequencer for count loads, tree build and bit-serial decode.
// ----------------------------------------------------------------------------
module hdfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              kind_i,
  output logic              s_tready_o,
  input  hdfc_pkg::dp_stat_t stat_i,
  output hdfc_pkg::dp_cmd_t  cmd_o
);
  import hdfc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          if (kind_i == KindLoad) begin
            cmd_o.load = 1'b1;
          end else if (!stat_i.stream_done) begin
            cmd_o.byte_start = 1'b1;
            if (stat_i.tree_ready) begin
              state_d = StBitRd;
            end else begin
              cmd_o.clr_start = 1'b1;
              state_d = StClr;
            end
          end
        end
      end
      StClr: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = StScanStart;
      end
      StScanStart: begin
        cmd_o.scan_start = 1'b1;
        state_d = StScan;
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = StScanTail;
      end
      StScanTail: begin
        state_d = StMark;
      end
      StMark: begin
        cmd_o.mark = 1'b1;
        if (stat_i.second_pick && stat_i.build_last) begin
          state_d = StBitRd;
        end else begin
          state_d = StScanStart;
        end
      end
      StBitRd: begin
        state_d = StBitEv;
      end
      StBitEv: begin
        if (!(stat_i.leaf && stat_i.pend_valid && !stat_i.slot)) begin
          cmd_o.bit_eval = 1'b1;
          if (stat_i.end_hit || stat_i.bit_last) begin
            state_d = StFlush;
          end else begin
            state_d = StBitRd;
          end
        end
      end
      StFlush: begin
        if (!stat_i.pend_valid || stat_i.slot) begin
          cmd_o.flush = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

### hw/rtl/hdfc_dp.sv
// ----------------------------------------------------------------------------
// hdfc_dp
// Node weight, parent and child memories, lightest-node scan, tree walk
// and result output register.
// ----------------------------------------------------------------------------
`include "huffman_decoder_from_counts_defines.svh"

module hdfc_dp #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hdfc_pkg::dp_cmd_t           cmd_i,
  input  logic [hdfc_pkg::SymW-1:0]   symbol_i,
  input  logic [hdfc_pkg::CountW-1:0] count_i,
  input  logic [hdfc_pkg::SymW-1:0]   packed_byte_i,
  output hdfc_pkg::dp_stat_t          stat_o,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [hdfc_pkg::SymW-1:0]   m_tdata_o,
  output logic                        m_tuser_o,
  output logic                        m_tlast_o
);
  import hdfc_pkg::*;

  localparam logic [WeightW-1:0] CntMask = WeightW'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [NodeW-1:0]   idx_q, made_q, best_q, a_q, scan_addr_q, walk_q;
  logic               pick_q, found_q, scan_vld_q;
  logic [WeightW-1:0] best_w_q, wa_q, limit_q;
  logic [2:0]         bit_q;
  logic [SymW-1:0]    byte_q;
  logic [CountW-1:0]  tally_q;
  logic               tree_ready_q, done_q;
  logic [Symbols-1:0] leaf_valid_q;
  logic               pend_valid_q, pend_end_q;
  logic [SymW-1:0]    pend_byte_q;
  logic               out_valid_q, out_end_q, out_last_q;
  logic [SymW-1:0]    out_byte_q;

  logic [WeightW-1:0] count_m, w_rdata, w_eff, w_wdata;
  logic [NodeW-1:0]   w_waddr, hp_waddr;
  logic               w_we, hp_we, hp_rdata, ch_we, cand;
  logic [ChildW-1:0]  ch_rdata;
  logic [NodeW-1:0]   next_node;
  logic               leaf, end_hit, slot, push;
  logic [CountW:0]    tally_inc;

  assign count_m = {{(WeightW-CountW){1'b0}}, count_i} & CntMask;

  assign w_we    = cmd_i.load | (cmd_i.mark & pick_q);
  assign w_waddr = cmd_i.load ? {1'b0, symbol_i} : made_q;
  assign w_wdata = cmd_i.load ? count_m : wa_q + best_w_q;

  hdfc_ram #(.WIDTH(WeightW), .DEPTH(Nodes)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (idx_q),
    .rdata_o (w_rdata)
  );

  assign hp_we    = cmd_i.clr_step | cmd_i.mark;
  assign hp_waddr = cmd_i.mark ? best_q : idx_q;

  hdfc_ram #(.WIDTH(1), .DEPTH(Nodes)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (hp_we),
    .waddr_i (hp_waddr),
    .wdata_i (cmd_i.mark),
    .raddr_i (idx_q),
    .rdata_o (hp_rdata)
  );

  assign ch_we = cmd_i.mark & pick_q;

  // right child in the upper half, left child in the lower half
  hdfc_ram #(.WIDTH(ChildW), .DEPTH(Inner)) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (made_q[SymW-1:0]),
    .wdata_i ({best_q, a_q}),
    .raddr_i (walk_q[SymW-1:0]),
    .rdata_o (ch_rdata)
  );

  // unloaded leaves weigh zero
  assign w_eff = (!scan_addr_q[NodeW-1] && !leaf_valid_q[scan_addr_q[SymW-1:0]]) ?
                 '0 : w_rdata;
  assign cand  = scan_vld_q && !hp_rdata && (!found_q || (w_eff < best_w_q));

  assign next_node = byte_q[bit_q] ? ch_rdata[ChildW-1:NodeW] : ch_rdata[NodeW-1:0];
  assign leaf      = !next_node[NodeW-1];
  assign tally_inc = {1'b0, tally_q} + {{CountW{1'b0}}, 1'b1};
  assign end_hit   = leaf && (next_node[SymW-1:0] == EndSym) &&
                     ({{(WeightW-CountW-1){1'b0}}, tally_inc} >= limit_q);

  assign slot = !out_valid_q || m_tready_i;
  assign push = pend_valid_q && ((cmd_i.bit_eval && leaf) || cmd_i.flush);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      made_q       <= FirstInner;
      pick_q       <= 1'b0;
      found_q      <= 1'b0;
      scan_vld_q   <= 1'b0;
      walk_q       <= RootNode;
      bit_q        <= '0;
      tally_q      <= '0;
      limit_q      <= '0;
      tree_ready_q <= 1'b0;
      done_q       <= 1'b0;
      leaf_valid_q <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      scan_vld_q <= cmd_i.scan_step;

      if (cmd_i.clr_start || cmd_i.scan_start) begin
        idx_q <= '0;
      end else if (cmd_i.clr_step || cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
      end

      if (cmd_i.clr_start) begin
        made_q <= FirstInner;
        pick_q <= 1'b0;
      end else if (cmd_i.mark) begin
        pick_q <= !pick_q;
        if (pick_q) made_q <= made_q + 1'b1;
      end

      if (cmd_i.scan_start) begin
        found_q <= 1'b0;
      end else if (cand) begin
        found_q <= 1'b1;
      end

      if (cmd_i.mark && pick_q && (made_q == RootNode)) begin
        tree_ready_q <= 1'b1;
        walk_q       <= RootNode;
      end

      if (cmd_i.load) begin
        leaf_valid_q[symbol_i] <= 1'b1;
        if (symbol_i == EndSym) limit_q <= count_m;
        tree_ready_q <= 1'b0;
        done_q       <= 1'b0;
        tally_q      <= '0;
        walk_q       <= RootNode;
      end

      if (cmd_i.byte_start) bit_q <= '0;

      if (cmd_i.bit_eval) begin
        bit_q <= bit_q + 1'b1;
        if (leaf) begin
          walk_q       <= RootNode;
          pend_valid_q <= 1'b1;
          if (next_node[SymW-1:0] == EndSym) tally_q <= tally_inc[CountW-1:0];
          if (end_hit) done_q <= 1'b1;
        end else begin
          walk_q <= next_node;
        end
      end

      if (cmd_i.flush) pend_valid_q <= 1'b0;

      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q <= idx_q;
    if (cand) begin
      best_q   <= scan_addr_q;
      best_w_q <= w_eff;
    end
    if (cmd_i.mark && !pick_q) begin
      a_q  <= best_q;
      wa_q <= best_w_q;
    end
    if (cmd_i.byte_start) byte_q <= packed_byte_i;
    if (cmd_i.bit_eval && leaf) begin
      pend_byte_q <= end_hit ? '0 : next_node[SymW-1:0];
      pend_end_q  <= end_hit;
    end
    if (push) begin
      out_byte_q <= pend_byte_q;
      out_end_q  <= pend_end_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign stat_o.stream_done = done_q;
  assign stat_o.tree_ready  = tree_ready_q;
  assign stat_o.clr_last    = (idx_q == RootNode);
  assign stat_o.scan_last   = (idx_q == made_q - 1'b1);
  assign stat_o.second_pick = pick_q;
  assign stat_o.build_last  = (made_q == RootNode);
  assign stat_o.bit_last    = (bit_q == 3'd7);
  assign stat_o.leaf        = leaf;
  assign stat_o.end_hit     = end_hit;
  assign stat_o.pend_valid  = pend_valid_q;
  assign stat_o.slot        = slot;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_byte_q;
  assign m_tuser_o  = out_end_q;
  assign m_tlast_o  = out_last_q;

  `HDFC_ASSERT_NEVER(a_push_overrun, push && out_valid_q && !m_tready_i, "result overwritten")
  `HDFC_ASSERT_NEVER(a_walk_inner, walk_q < FirstInner, "walk left inner nodes")
  `HDFC_ASSERT_NEVER(a_made_range, made_q < FirstInner, "node counter out of range")
  `HDFC_ASSERT(a_end_pending, $rose(done_q) |-> pend_valid_q && pend_end_q, "end result lost")

endmodule

### hw/rtl/huffman_decoder_from_counts.sv
// Count load: taken in the idle state. Packed byte: each code bit takes a child memory read, then a step;
// a byte ends early when the end marker stops it, and output stalls hold the walk;
// up to 8 results per byte; no new input is taken until the byte is done.
// First byte after any load rebuilds the tree: a clear of all 511 parent flags, then a
// lightest-node scan over the nodes made so far for each pick.
// Reset clears the leaf-loaded flags, the end tally and the tree-ready and stream-done flags.
// ----------------------------------------------------------------------------
// huffman_decoder_from_counts
// Static Huffman decoder: loads 256 symbol counts, builds the tree, decodes bytes.
// ----------------------------------------------------------------------------
module huffman_decoder_from_counts #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [7:0] symbol, [31:8] count, [39:32] packed_byte
  input  logic [hdfc_pkg::InW-1:0]   s_axis_tdata_i,
  // [0] kind
  input  logic                       s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [7:0] decoded_byte
  output logic [hdfc_pkg::SymW-1:0]  m_axis_tdata_o,
  // [0] end_reached
  output logic                       m_axis_tuser_o,
  output logic                       m_axis_tlast_o
);
  import hdfc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hdfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .kind_i     (s_axis_tuser_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hdfc_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .symbol_i      (s_axis_tdata_i[SymW-1:0]),
    .count_i       (s_axis_tdata_i[SymW+CountW-1:SymW]),
    .packed_byte_i (s_axis_tdata_i[InW-1:SymW+CountW]),
    .stat_o        (stat),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_tready_i    (m_axis_tready_i),
    .m_tdata_o     (m_axis_tdata_o),
    .m_tuser_o     (m_axis_tuser_o),
    .m_tlast_o     (m_axis_tlast_o)
  );

endmodule
